// ----- src/pps_pkg.sv -----
// Shared types and constants for the nonpreemptive priority scheduler.
`default_nettype none

package pps_pkg;

    localparam int SLOT_W    = 4;
    localparam int ID_W      = 8;
    localparam int ARRIVAL_W = 16;
    localparam int PRIO_W    = 8;
    localparam int BURST_W   = 16;
    localparam int NOW_W     = 32;
    localparam int REM_W     = 16;
    localparam int READY_W   = 5;
    localparam int SW_W      = 16;
    localparam int KEY_W     = PRIO_W + ARRIVAL_W + ID_W;

    localparam int READY_MAX = 31;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_TICK = 1'b1
    } t_func;

    // Request payload, last field in the lowest bits.
    typedef struct packed {
        logic [BURST_W-1:0]   burst_time;
        logic [PRIO_W-1:0]    prio_level;
        logic [ARRIVAL_W-1:0] arrival_time;
        logic [ID_W-1:0]      task_id;
        logic [SLOT_W-1:0]    slot;
    } t_request;

    localparam int REQ_W       = $bits(t_request);
    localparam int REQ_BYTES_W = ((REQ_W + 7) / 8) * 8;

    // One task table entry as stored in the RAM.
    typedef struct packed {
        logic [ID_W-1:0]      ident;
        logic [ARRIVAL_W-1:0] arrival;
        logic [PRIO_W-1:0]    urgency;
        logic [REM_W-1:0]     remaining;
    } t_entry;

    // Result payload, last field in the lowest bits.
    typedef struct packed {
        logic                 all_done;
        logic [SW_W-1:0]      switch_total;
        logic [READY_W-1:0]   ready_count;
        logic [REM_W-1:0]     remaining_after;
        logic                 finished;
        logic                 dispatched;
        logic [ID_W-1:0]      run_task_id;
        logic [SLOT_W-1:0]    run_slot;
        logic                 cpu_busy;
        logic [NOW_W-1:0]     now_time;
    } t_result;

    localparam int RES_W       = $bits(t_result);
    localparam int RES_BYTES_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_PICK,
        S_UPD,
        S_FIN
    } t_state;

    // Selection key: lower wins; priority, then arrival, then id.
    function automatic logic [KEY_W-1:0] key_of(input t_entry e);
        key_of = {e.urgency, e.arrival, e.ident};
    endfunction

endpackage

`default_nettype wire

// ----- src/pps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- src/pps_scan.sv -----
// Shared compare unit: tracks the best ready entry and the ready count over a scan.
`default_nettype none

module pps_scan
    import pps_pkg::*;
#(
    parameter int AW = 4,
    parameter int CW = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clear,
    input  wire logic             i_en,
    input  wire logic             i_live,
    input  wire logic [AW-1:0]    i_idx,
    input  wire t_entry           i_ent,
    input  wire logic [NOW_W-1:0] i_sel_time,
    input  wire logic [NOW_W-1:0] i_cnt_time,
    output logic                  o_found,
    output logic      [AW-1:0]    o_best_idx,
    output logic      [ID_W-1:0]  o_best_id,
    output logic      [CW-1:0]    o_count
);

    logic              r_found;
    logic [KEY_W-1:0]  r_key;
    logic [AW-1:0]     r_idx;
    logic [CW-1:0]     r_count;

    logic [NOW_W-1:0]  arr_ext;
    logic [KEY_W-1:0]  cand_key;
    logic              rdy_sel;
    logic              rdy_cnt;
    logic              better;

    assign arr_ext  = NOW_W'(i_ent.arrival);
    assign cand_key = key_of(i_ent);
    assign rdy_sel  = i_live && (arr_ext <= i_sel_time);
    assign rdy_cnt  = i_live && (arr_ext <= i_cnt_time);
    // strict compare keeps the lower slot on a full tie
    assign better   = !r_found || (cand_key < r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_found <= 1'b0;
            r_count <= '0;
        end else if (i_en) begin
            if (rdy_sel && better) begin
                r_found <= 1'b1;
            end
            if (rdy_cnt) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && rdy_sel && better) begin
            r_key <= cand_key;
            r_idx <= i_idx;
        end
    end

    assign o_found    = r_found;
    assign o_best_idx = r_idx;
    assign o_best_id  = r_key[ID_W-1:0];
    assign o_count    = r_count;

endmodule

`default_nettype wire

// ----- src/nonpreemptive_priority_scheduler.sv -----
// Top level of the nonpreemptive priority scheduler: sequencer, task flags and result register.
//
// Usage:
//   Requests enter on the s_axis channel. tuser carries the function: load writes one
//   task slot from tdata, tick advances time by one and runs the current task, first
//   dispatching the most urgent ready entry when nothing is running. Every request
//   returns exactly one result on the m_axis channel.
//   Flow: every request walks the whole task table through one RAM read port and
//   one key comparator, one entry per cycle. A load adds the table write before the
//   scan and a tick that runs a task adds the remaining-time read-modify-write after
//   it. The next request is taken only once the last result is registered, so the
//   block never holds more than one request at a time.
//   s_axis tready is high only between requests.
//   Reset: synchronous, active low. Clears the slot valid and done flags, time,
//   the running task, the switch counter and the result valid flag. Task fields
//   in the RAM are not cleared; an unloaded slot is read but never counted or selected.
//   Stall: a finished result sits in the output register until m_axis tready;
//   a new request is still accepted meanwhile and holds at its last step until
//   the register frees.
`default_nettype none

module nonpreemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // tdata, lowest bit up: slot(4) task_id(8) arrival_time(16) prio_level(8)
    // burst_time(16), zero pad(4)
    input  wire logic [REQ_BYTES_W-1:0] i_s_axis_tdata,
    // tuser: func(1), 0 = load, 1 = tick
    input  wire logic                   i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // tdata, lowest bit up: now_time(32) cpu_busy(1) run_slot(4) run_task_id(8)
    // dispatched(1) finished(1) remaining_after(16) ready_count(5)
    // switch_total(16) all_done(1), zero pad(3)
    output logic      [RES_BYTES_W-1:0] o_m_axis_tdata
);

    localparam int AW    = $clog2(MAX_TASKS);
    localparam int CW    = $clog2(MAX_TASKS + 1);
    localparam int ENT_W = $bits(t_entry);

    // ---------------------------------------------------------------- state
    t_state               r_state, n_state;
    t_request             r_req;
    t_func                r_func;
    logic [AW-1:0]        r_idx;
    logic                 r_cand_vld;
    logic [AW-1:0]        r_cand_idx;

    logic [MAX_TASKS-1:0] r_valid;
    logic [MAX_TASKS-1:0] r_done;
    logic [NOW_W-1:0]     r_time;
    logic [AW-1:0]        r_run_slot;
    logic                 r_run_valid;
    logic [ID_W-1:0]      r_last_id;
    logic                 r_last_valid;
    logic [SW_W-1:0]      r_sw;

    // per-request result fields
    logic                 r_busy;
    logic                 r_disp;
    logic                 r_fin;
    logic [SLOT_W-1:0]    r_rslot;
    logic [ID_W-1:0]      r_rid;
    logic [REM_W-1:0]     r_rem;

    t_result              r_out;
    logic                 r_o_valid;

    // ---------------------------------------------------------------- wires
    logic                 accept;
    logic                 out_free;
    t_request             req_in;
    logic [AW-1:0]        slot_addr;
    logic                 slot_ok;
    logic [NOW_W-1:0]     t_next;
    logic [NOW_W-1:0]     cnt_time;
    logic                 run_now;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    t_entry               ram_wdata;
    logic [AW-1:0]        ram_raddr;
    t_entry               ram_rdata;
    logic [REM_W-1:0]     rem_new;

    logic                 scan_clear;
    logic                 scan_found;
    logic [AW-1:0]        scan_best_idx;
    logic [ID_W-1:0]      scan_best_id;
    logic [CW-1:0]        scan_count;
    logic                 cand_live;

    logic                 excl;
    logic [CW-1:0]        cnt_adj;
    logic [READY_W-1:0]   ready_sat;
    t_result              res;

    assign accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_o_valid || i_m_axis_tready;
    assign req_in    = t_request'(i_s_axis_tdata[REQ_W-1:0]);
    assign slot_addr = AW'(r_req.slot);
    assign slot_ok   = int'(r_req.slot) < MAX_TASKS;

    // time saturates at all ones
    assign t_next   = (r_time == '1) ? r_time : r_time + 1'b1;
    // ready count is taken at the time after the request
    assign cnt_time = (r_func == FUNC_TICK) ? t_next : r_time;

    // a tick runs a task if one is running or the scan found one
    assign run_now = (r_func == FUNC_TICK) && (r_run_valid || scan_found);

    // remaining time saturates at zero
    assign rem_new = (ram_rdata.remaining == '0) ? '0 : ram_rdata.remaining - 1'b1;

    assign cand_live = r_valid[r_cand_idx] && !r_done[r_cand_idx];

    // ---------------------------------------------------------------- task RAM
    pps_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_TASKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- compare unit
    pps_scan #(
        .AW (AW),
        .CW (CW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (scan_clear),
        .i_en       (r_cand_vld),
        .i_live     (cand_live),
        .i_idx      (r_cand_idx),
        .i_ent      (ram_rdata),
        .i_sel_time (r_time),
        .i_cnt_time (cnt_time),
        .o_found    (scan_found),
        .o_best_idx (scan_best_idx),
        .o_best_id  (scan_best_id),
        .o_count    (scan_count)
    );

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (t_func'(i_s_axis_tuser) == FUNC_TICK) ? S_SCAN : S_LOAD;
                end
            end
            S_LOAD:  n_state = S_SCAN;
            S_SCAN: begin
                if (r_idx == AW'(MAX_TASKS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_PICK;
            S_PICK:  n_state = run_now ? S_UPD : S_FIN;
            S_UPD:   n_state = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- state outputs
    always_comb begin
        o_s_axis_tready        = 1'b0;
        scan_clear             = 1'b0;
        ram_we                 = 1'b0;
        ram_waddr              = slot_addr;
        ram_wdata.ident        = r_req.task_id;
        ram_wdata.arrival      = r_req.arrival_time;
        ram_wdata.urgency      = r_req.prio_level;
        ram_wdata.remaining    = r_req.burst_time;
        ram_raddr              = r_idx;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                scan_clear      = 1'b1;
            end
            S_LOAD: begin
                // drop loads beyond the table
                ram_we     = slot_ok;
                scan_clear = 1'b1;
            end
            S_SCAN, S_DRAIN, S_FIN: begin
            end
            S_PICK: begin
                ram_raddr = r_run_valid ? r_run_slot : scan_best_idx;
            end
            S_UPD: begin
                ram_we              = 1'b1;
                ram_waddr           = r_run_slot;
                ram_wdata           = ram_rdata;
                ram_wdata.remaining = rem_new;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- result assembly
    // the slot that ran (or keeps running) was counted by the scan; take it out
    assign excl    = (r_func == FUNC_TICK) ? r_busy : r_run_valid;
    assign cnt_adj = scan_count - CW'(excl);
    assign ready_sat = (int'(cnt_adj) > READY_MAX) ? READY_W'(READY_MAX) : READY_W'(cnt_adj);

    always_comb begin
        res.now_time        = cnt_time;
        res.cpu_busy        = r_busy;
        res.run_slot        = r_rslot;
        res.run_task_id     = r_rid;
        res.dispatched      = r_disp;
        res.finished        = r_fin;
        res.remaining_after = r_rem;
        res.ready_count     = ready_sat;
        res.switch_total    = r_sw;
        res.all_done        = ~|(r_valid & ~r_done);
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_cand_vld   <= 1'b0;
            r_valid      <= '0;
            r_done       <= '0;
            r_time       <= '0;
            r_run_slot   <= '0;
            r_run_valid  <= 1'b0;
            r_last_id    <= '0;
            r_last_valid <= 1'b0;
            r_sw         <= '0;
            r_busy       <= 1'b0;
            r_disp       <= 1'b0;
            r_fin        <= 1'b0;
            r_rslot      <= '0;
            r_rid        <= '0;
            r_rem        <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cand_vld <= (r_state == S_SCAN);

            // post a finished result, or drop the one the receiver took
            if (r_state == S_FIN && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_idx  <= '0;
                        r_busy <= 1'b0;
                        r_disp <= 1'b0;
                        r_fin  <= 1'b0;
                        r_rslot <= '0;
                        r_rid  <= '0;
                        r_rem  <= '0;
                    end
                end
                S_LOAD: begin
                    if (slot_ok) begin
                        r_valid[slot_addr] <= 1'b1;
                        r_done[slot_addr]  <= 1'b0;
                        // rewriting the running slot cancels the run
                        if (r_run_valid && r_run_slot == slot_addr) begin
                            r_run_valid <= 1'b0;
                        end
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                end
                S_DRAIN: begin
                end
                S_PICK: begin
                    if (run_now) begin
                        r_busy <= 1'b1;
                        if (!r_run_valid) begin
                            // dispatch; count a switch only when the id changes
                            r_run_valid  <= 1'b1;
                            r_run_slot   <= scan_best_idx;
                            r_disp       <= 1'b1;
                            r_last_id    <= scan_best_id;
                            r_last_valid <= 1'b1;
                            if (r_last_valid && r_last_id != scan_best_id && r_sw != '1) begin
                                r_sw <= r_sw + 1'b1;
                            end
                        end
                    end
                end
                S_UPD: begin
                    r_rslot <= SLOT_W'(r_run_slot);
                    r_rid   <= ram_rdata.ident;
                    r_rem   <= rem_new;
                    if (rem_new == '0) begin
                        r_fin               <= 1'b1;
                        r_done[r_run_slot]  <= 1'b1;
                        r_run_valid         <= 1'b0;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_time <= cnt_time;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // candidate index and result payload need no reset
    always_ff @(posedge i_clk) begin
        r_cand_idx <= r_idx;
        if (accept) begin
            r_req  <= req_in;
            r_func <= t_func'(i_s_axis_tuser);
        end
        if (r_state == S_FIN && out_free) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {{(RES_BYTES_W - RES_W){1'b0}}, r_out};

    // ---------------------------------------------------------------- assertions
`ifndef ASSERT_OFF
    // an accepted request always starts the sequencer
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // the running task always points at a loaded, unfinished slot
    a_run_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> (r_valid[r_run_slot] && !r_done[r_run_slot]))
        else $error("running slot is not a live entry");

    // a dispatch from an idle processor marks the run and the result
    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && run_now && !r_run_valid) |=> (r_run_valid && r_disp && r_busy))
        else $error("dispatch did not start a run");
`endif

endmodule

`default_nettype wire

// ----- dv/pps_tb_pkg.sv -----
// Scoreboard class for the nonpreemptive priority scheduler testbench.
`timescale 1ns / 100ps

package pps_tb_pkg;

    import pps_pkg::*;

    localparam int TB_SLOTS = 16;

    class sched_scoreboard;

        // Mirror of the task table and of the scheduler state.
        bit                   slot_loaded[TB_SLOTS];
        bit                   slot_done[TB_SLOTS];
        logic [ID_W-1:0]      slot_ident[TB_SLOTS];
        logic [ARRIVAL_W-1:0] slot_arrival[TB_SLOTS];
        logic [PRIO_W-1:0]    slot_urgency[TB_SLOTS];
        logic [REM_W-1:0]     slot_remaining[TB_SLOTS];
        logic [NOW_W-1:0]     clock_now;
        logic [SLOT_W-1:0]    run_idx;
        bit                   run_active;
        logic [ID_W-1:0]      prev_ident;
        bit                   prev_ident_valid;
        logic [SW_W-1:0]      switch_cnt;

        t_result              expected_q[$];
        int                   mismatches;
        int                   checked;

        function new();
            foreach (slot_loaded[i]) begin
                slot_loaded[i]    = 1'b0;
                slot_done[i]      = 1'b0;
                slot_ident[i]     = '0;
                slot_arrival[i]   = '0;
                slot_urgency[i]   = '0;
                slot_remaining[i] = '0;
            end
            clock_now        = '0;
            run_idx          = '0;
            run_active       = 1'b0;
            prev_ident       = '0;
            prev_ident_valid = 1'b0;
            switch_cnt       = '0;
            mismatches       = 0;
            checked          = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit is_ready(int i, logic [NOW_W-1:0] t);
            return slot_loaded[i] && !slot_done[i] && (NOW_W'(slot_arrival[i]) <= t);
        endfunction

        // True when slot a beats slot b: urgency, then arrival, then id.
        function bit wins(int a, int b);
            if (slot_urgency[a] != slot_urgency[b])
                return slot_urgency[a] < slot_urgency[b];
            if (slot_arrival[a] != slot_arrival[b])
                return slot_arrival[a] < slot_arrival[b];
            return slot_ident[a] < slot_ident[b];
        endfunction

        function int ready_total(logic [NOW_W-1:0] t, bit skip, int skip_idx);
            int n;
            n = 0;
            for (int i = 0; i < TB_SLOTS; i++)
                if (is_ready(i, t) && !(skip && i == skip_idx))
                    n++;
            return n;
        endfunction

        function bit all_finished();
            for (int i = 0; i < TB_SLOTS; i++)
                if (slot_loaded[i] && !slot_done[i])
                    return 1'b0;
            return 1'b1;
        endfunction

        // Advance the mirrored scheduler by one accepted request and queue its result.
        function void note_request(t_func f, t_request r);
            t_result          res;
            logic [NOW_W-1:0] t;
            logic [NOW_W-1:0] t_next;
            int               sel;
            int               s;
            bit               found;
            int               rdy;
            res = '0;
            if (f == FUNC_LOAD) begin
                s                 = int'(r.slot);
                slot_loaded[s]    = 1'b1;
                slot_done[s]      = 1'b0;
                slot_ident[s]     = r.task_id;
                slot_arrival[s]   = r.arrival_time;
                slot_urgency[s]   = r.prio_level;
                slot_remaining[s] = r.burst_time;
                if (run_active && run_idx == r.slot)
                    run_active = 1'b0;
                rdy = ready_total(clock_now, run_active, int'(run_idx));
            end else begin
                t      = clock_now;
                t_next = (t == '1) ? t : t + 1;
                if (!run_active) begin
                    found = 1'b0;
                    sel   = 0;
                    for (int i = 0; i < TB_SLOTS; i++) begin
                        if (is_ready(i, t) && (!found || wins(i, sel))) begin
                            sel   = i;
                            found = 1'b1;
                        end
                    end
                    if (found) begin
                        run_active     = 1'b1;
                        run_idx        = SLOT_W'(sel);
                        res.dispatched = 1'b1;
                        if (prev_ident_valid && prev_ident != slot_ident[sel] &&
                            switch_cnt != '1)
                            switch_cnt++;
                        prev_ident       = slot_ident[sel];
                        prev_ident_valid = 1'b1;
                    end
                end
                if (run_active) begin
                    s = int'(run_idx);
                    if (slot_remaining[s] != 0)
                        slot_remaining[s]--;
                    res.cpu_busy        = 1'b1;
                    res.run_slot        = run_idx;
                    res.run_task_id     = slot_ident[s];
                    res.remaining_after = slot_remaining[s];
                    if (slot_remaining[s] == 0) begin
                        slot_done[s] = 1'b1;
                        run_active   = 1'b0;
                        res.finished = 1'b1;
                    end
                    clock_now = t_next;
                    rdy       = ready_total(clock_now, 1'b1, s);
                end else begin
                    clock_now = t_next;
                    rdy       = ready_total(clock_now, 1'b0, 0);
                end
            end
            if (rdy > READY_MAX)
                rdy = READY_MAX;
            res.now_time     = clock_now;
            res.ready_count  = READY_W'(rdy);
            res.switch_total = switch_cnt;
            res.all_done     = all_finished();
            expected_q = {expected_q, res};
        endfunction

        function void field_check(string name, logic [NOW_W-1:0] want,
                                  logic [NOW_W-1:0] seen);
            if (want !== seen) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH result %0d %s: expected 0x%0h, got 0x%0h",
                             checked, name, want, seen);
            end
        endfunction

        // Compare one delivered result against the oldest expectation.
        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH unexpected result 0x%0h", got);
                return;
            end
            want = expected_q.pop_front();
            field_check("now_time", want.now_time, got.now_time);
            field_check("cpu_busy", want.cpu_busy, got.cpu_busy);
            field_check("run_slot", want.run_slot, got.run_slot);
            field_check("run_task_id", want.run_task_id, got.run_task_id);
            field_check("dispatched", want.dispatched, got.dispatched);
            field_check("finished", want.finished, got.finished);
            field_check("remaining_after", want.remaining_after, got.remaining_after);
            field_check("ready_count", want.ready_count, got.ready_count);
            field_check("switch_total", want.switch_total, got.switch_total);
            field_check("all_done", want.all_done, got.all_done);
            checked++;
        endfunction

    endclass

endpackage

// ----- dv/tb_top.sv -----
// Top-level testbench of the nonpreemptive priority scheduler.
`timescale 1ns / 100ps

module tb_top;

    import pps_pkg::*;
    import pps_tb_pkg::*;

    localparam int PHASE_ITEMS  = 330;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_WAIT  = TB_SLOTS + 10;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_ready;
    logic [REQ_BYTES_W-1:0] req_data;
    t_func                  req_func;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    logic [RES_BYTES_W-1:0] res_data;

    int                     tx_idle_pct;
    int                     rx_stall_pct;
    int                     items_sent;
    int                     quiet_cycles;

    sched_scoreboard        sb;

    nonpreemptive_priority_scheduler #(
        .MAX_TASKS(TB_SLOTS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .i_s_axis_tuser  (req_func),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk) begin
        res_ready = ($urandom_range(99) >= rx_stall_pct);
    end

    // Check every delivered result.
    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(t_result'(res_data[RES_W-1:0]));
    end

    // Watchdog: abort when neither side moves anything for too long.
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("nonpreemptive_priority_scheduler verification failed");
                $finish;
            end
        end
    end

    // Offer one request, holding it until accepted; returns at a falling edge.
    task automatic send_request(input t_func f, input t_request r);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req_func  = f;
        req_data  = REQ_BYTES_W'(r);
        do @(posedge clk); while (!req_ready);
        sb.note_request(f, r);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic load_task(input int slot, input int id, input int arr, input int prio,
                             input int burst);
        t_request r;
        r.slot         = SLOT_W'(slot);
        r.task_id      = ID_W'(id);
        r.arrival_time = ARRIVAL_W'(arr);
        r.prio_level   = PRIO_W'(prio);
        r.burst_time   = BURST_W'(burst);
        send_request(FUNC_LOAD, r);
    endtask

    // Tick requests carry random payload bits, which the block must ignore.
    task automatic tick(input int n);
        logic [63:0] noise;
        repeat (n) begin
            noise = {$urandom(), $urandom()};
            send_request(FUNC_TICK, noise[REQ_W-1:0]);
        end
    endtask

    task automatic hold_until_drained();
        req_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Arrival a few ticks from the current time, clipped to the field range.
    function automatic int near_arrival(int spread);
        longint a;
        a = longint'(sb.clock_now) + $urandom_range(spread);
        return (a > 65535) ? 65535 : int'(a);
    endfunction

    // One random burst of work: mostly a well-formed batch of loads followed by
    // ticks, sometimes a load that never becomes ready or that cancels the run.
    task automatic random_batch();
        int kind;
        int n_loads;
        int id;
        int prio;
        int burst;
        kind = $urandom_range(99);
        if (kind < 8) begin
            // far-future entry with full-range fields; never ready within the run
            load_task($urandom_range(15), $urandom_range(255), $urandom_range(65535, 4096),
                      $urandom_range(255), $urandom_range(65535));
        end else if (kind < 14 && sb.run_active) begin
            // overwrite the slot that is running
            load_task(int'(sb.run_idx), $urandom_range(255), near_arrival(4),
                      $urandom_range(7), $urandom_range(6));
        end else begin
            n_loads = $urandom_range(5, 1);
            repeat (n_loads) begin
                id    = ($urandom_range(1)) ? $urandom_range(255) : $urandom_range(3);
                prio  = ($urandom_range(3) != 0) ? $urandom_range(3) : $urandom_range(255);
                burst = ($urandom_range(9) != 0) ? $urandom_range(5) : $urandom_range(40, 6);
                load_task($urandom_range(15), id, near_arrival(6), prio, burst);
            end
        end
        tick($urandom_range(25, 1));
    endtask

    initial begin
        int phase_end;
        sb           = new();
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_func     = FUNC_LOAD;
        req_data     = '0;
        tx_idle_pct  = 21;
        rx_stall_pct = 48;
        items_sent   = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part.
        tick(1);                                // idle tick on an empty table
        load_task(0, 255, 0, 255, 1);
        load_task(15, 0, 0, 255, 2);            // id breaks the tie with slot 0
        load_task(7, 0, 0, 255, 0);             // same key as slot 15: lower slot wins
        load_task(3, 9, 65535, 0, 65535);       // latest arrival, never ready
        tick(1);                                // zero service time: one tick, done
        tick(2);                                // same id again: no switch counted
        tick(1);                                // id change: switch counted
        tick(1);                                // nothing ready: idle
        load_task(5, 17, 0, 0, 65535);          // longest service time
        tick(1);
        load_task(2, 3, 1, 0, 3);               // equally urgent arrival must not preempt
        tick(1);
        load_task(5, 18, 5, 1, 2);              // overwrite cancels the running task
        tick(4);
        load_task(3, 9, 0, 128, 1);             // replace the far-future entry
        tick(5);
        hold_until_drained();

        // Random part: receiver-heavy stalling, then sender-heavy idling, then none.
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct  = (ph == 0) ? 21 : (ph == 1) ? 48 : 0;
            rx_stall_pct = (ph == 0) ? 48 : (ph == 1) ? 21 : 0;
            phase_end    = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                random_batch();
            hold_until_drained();
        end

        repeat (SETTLE_WAIT) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("nonpreemptive_priority_scheduler verification clean");
        end else begin
            $display("nonpreemptive_priority_scheduler verification failed");
        end
        $finish;
    end

endmodule

// ----- nonpreemptive_priority_scheduler.f -----
src/pps_pkg.sv
src/pps_ram.sv
src/pps_scan.sv
src/nonpreemptive_priority_scheduler.sv
dv/pps_tb_pkg.sv
dv/tb_top.sv
